>>> rtl/mvts_pkg.sv
// Shared types and constants for the minimum-vruntime task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mvts_pkg;

  localparam int MaxTasksDef = 16;
  localparam int IdW = 16;
  localparam int VrW = 48;
  localparam int WeightW = 16;
  localparam int ElapsedW = 16;
  localparam int ProdW = WeightW + ElapsedW;
  localparam int NiceIdxW = 3;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 3;
  localparam int NumWeights = 5;
  localparam logic [WeightW-1:0] WeightReset = 16'd256;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegWeightM2 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWeightM1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWeightZ0 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWeightP1 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWeightP2 = 3'd4;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  // Operation codes.
  localparam logic OpAdd  = 1'b0;
  localparam logic OpTick = 1'b1;

  // One table entry; the nice level is held as a weight index from 0 to 4.
  typedef struct packed {
    logic [IdW-1:0]      id;
    logic [NiceIdxW-1:0] nice;
    logic [VrW-1:0]      vr;
  } entry_t;

  // Per-cell controls for one cycle.
  typedef struct packed {
    logic wr;
    logic pair_left;
    logic pair_right;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/mvts_if.sv
// Input and output channel interfaces of the scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface mvts_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [15:0]       task_id;
  logic signed [2:0] nice_level;
  logic [15:0]       elapsed_time;

  modport source (output valid, operation, task_id, nice_level, elapsed_time,
                  input ready);
  modport sink (input valid, operation, task_id, nice_level, elapsed_time,
                output ready);
endinterface

interface mvts_out_if #(
  parameter int CountW = 5
);
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [15:0]       next_task_id;
  logic [47:0]       next_vruntime;
  logic [CountW-1:0] task_count;

  modport source (output valid, status, next_task_id, next_vruntime, task_count,
                  input ready);
  modport sink (input valid, status, next_task_id, next_vruntime, task_count,
                output ready);
endinterface
`default_nettype wire

>>> rtl/mvts_cell.sv
// One table cell: holds an entry and compares-and-swaps with a neighbour.
`timescale 1ns / 1ps
`default_nettype none
module mvts_cell (
  input  wire                       clk_i,
  input  wire mvts_pkg::cell_ctrl_t ctrl_i,
  input  wire mvts_pkg::entry_t     wr_data_i,
  input  wire mvts_pkg::entry_t     left_i,
  input  wire mvts_pkg::entry_t     right_i,
  output mvts_pkg::entry_t          entry_o
);
  import mvts_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // Swaps only on a strict order violation, so equal runtimes keep their order.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.wr) begin
      entry_d = wr_data_i;
    end else if (ctrl_i.pair_right && (entry_q.vr > right_i.vr)) begin
      entry_d = right_i;
    end else if (ctrl_i.pair_left && (left_i.vr > entry_q.vr)) begin
      entry_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

>>> rtl/min_vruntime_task_scheduler_unit.sv
// Top level of the minimum-vruntime task scheduler.
//
// Words arrive on in_ch: an add places a task at the tail of the table with
// zero virtual runtime, a tick charges the head task elapsed_time times the
// weight of its nice level and then re-sorts the table. Every word yields
// one result word on out_ch carrying the status, the head task and the count.
// An add writes the tail cell as it is accepted and then loads the output
// register. A tick runs the multiply, the saturating add into the head cell,
// MaxTasks odd-even transposition phases along the row of cells, and the
// load of the output register. One word is worked on at a time; the next is
// accepted once the result is in the output register. The user must write
// the weights through the cfg port while the block is idle; the block does
// not enforce this. Reset empties the table and returns all weights to 1.0
// (Q8.8). If the receiver stalls, the result is held and the next word may be
// accepted, but its result waits until the held one has been taken.
`timescale 1ns / 1ps
`default_nettype none
module min_vruntime_task_scheduler_unit #(
  parameter int MaxTasks = mvts_pkg::MaxTasksDef
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [mvts_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire [mvts_pkg::WeightW-1:0]     cfg_data_i,
  mvts_in_if.sink                         in_ch,
  mvts_out_if.source                      out_ch
);
  import mvts_pkg::*;

  localparam int CountW = $clog2(MaxTasks + 1);
  localparam int PhaseW = $clog2(MaxTasks);
  localparam logic [CountW-1:0] CountFull = CountW'(MaxTasks);
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(MaxTasks - 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAdd  = 3'd1;
  localparam logic [2:0] StSort = 3'd2;
  localparam logic [2:0] StDone = 3'd3;

  logic [2:0]          state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [ProdW-1:0]    prod_q;
  logic [WeightW-1:0]  weight_q [NumWeights];
  logic                out_valid_q;

  entry_t              cell_data [MaxTasks];
  entry_t              wr_entry;
  entry_t              head;
  logic [WeightW-1:0]  head_weight;
  logic [VrW:0]        vr_sum;
  logic [NiceIdxW-1:0] nice_idx;
  logic                accept;
  logic                add_wr;
  logic                out_load;

  assign head = cell_data[0];
  assign in_ch.ready = (state_q == StIdle);
  assign accept = in_ch.valid && (state_q == StIdle);
  assign add_wr = accept && (in_ch.operation == OpAdd) && (count_q != CountFull);
  assign out_load = (state_q == StDone) && (!out_valid_q || out_ch.ready);

  // Out-of-range nice levels clamp to the nearest end.
  always_comb begin
    if (in_ch.nice_level < -3'sd2) begin
      nice_idx = 3'd0;
    end else if (in_ch.nice_level > 3'sd2) begin
      nice_idx = 3'd4;
    end else begin
      nice_idx = 3'(in_ch.nice_level + 3'sd2);
    end
  end

  always_comb begin
    case (head.nice)
      3'd0:    head_weight = weight_q[0];
      3'd1:    head_weight = weight_q[1];
      3'd2:    head_weight = weight_q[2];
      3'd3:    head_weight = weight_q[3];
      3'd4:    head_weight = weight_q[4];
      default: head_weight = '0;
    endcase
  end

  assign vr_sum = {1'b0, head.vr} + (VrW + 1)'(prod_q);

  always_comb begin
    wr_entry = '0;
    if (state_q == StAdd) begin
      wr_entry = head;
      wr_entry.vr = vr_sum[VrW] ? {VrW{1'b1}} : vr_sum[VrW-1:0];
    end else begin
      wr_entry.id = in_ch.task_id;
      wr_entry.nice = nice_idx;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    phase_d = phase_q;
    status_d = status_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StDone;
          status_d = StatusOk;
          if (in_ch.operation == OpAdd) begin
            if (count_q == CountFull) begin
              status_d = StatusFull;
            end else begin
              count_d = count_q + CountW'(1);
            end
          end else if (count_q == '0) begin
            status_d = StatusEmpty;
          end else begin
            state_d = StAdd;
          end
        end
      end
      StAdd: begin
        state_d = StSort;
        phase_d = '0;
      end
      StSort: begin
        phase_d = phase_q + PhaseW'(1);
        if (phase_q == PhaseLast) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      phase_q <= '0;
      status_q <= StatusOk;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= ProdW'(in_ch.elapsed_time) * ProdW'(head_weight);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumWeights; k++) begin
        weight_q[k] <= WeightReset;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegWeightM2: weight_q[0] <= cfg_data_i;
        RegWeightM1: weight_q[1] <= cfg_data_i;
        RegWeightZ0: weight_q[2] <= cfg_data_i;
        RegWeightP1: weight_q[3] <= cfg_data_i;
        RegWeightP2: weight_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < MaxTasks; i++) begin : g_cell
    localparam logic [CountW-1:0] Idx = CountW'(i);
    localparam logic [CountW-1:0] IdxNext = CountW'(i + 1);
    localparam logic Par = (i % 2) == 1;
    cell_ctrl_t ctrl;
    entry_t     left_data;
    entry_t     right_data;

    assign ctrl.wr = (add_wr && (count_q == Idx)) || ((state_q == StAdd) && (i == 0));
    assign ctrl.pair_right = (state_q == StSort) && (phase_q[0] == Par) && (IdxNext < count_q)
                             && (i < MaxTasks - 1);
    assign ctrl.pair_left = (state_q == StSort) && (i > 0) && (phase_q[0] != Par)
                            && (Idx < count_q);

    if (i == 0) begin : g_left_edge
      assign left_data = '0;
    end else begin : g_left
      assign left_data = cell_data[i-1];
    end
    if (i == MaxTasks - 1) begin : g_right_edge
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end

    mvts_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .wr_data_i (wr_entry),
      .left_i    (left_data),
      .right_i   (right_data),
      .entry_o   (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch.status <= status_q;
      out_ch.task_count <= count_q;
      if (count_q == '0) begin
        out_ch.next_task_id <= '0;
        out_ch.next_vruntime <= '0;
      end else begin
        out_ch.next_task_id <= head.id;
        out_ch.next_vruntime <= head.vr;
      end
    end
  end

  assign out_ch.valid = out_valid_q;

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the minimum-vruntime task scheduler unit.
`timescale 1ns / 1ps
module testbench;
  import mvts_pkg::*;

  localparam int MaxTasks = MaxTasksDef;
  localparam int CountW = $clog2(MaxTasks + 1);
  localparam int LongHold = 300;
  localparam int CycleLimit = 500000;
  localparam logic [CfgIdxW-1:0] WeightRegs[NumWeights] =
    '{RegWeightM2, RegWeightM1, RegWeightZ0, RegWeightP1, RegWeightP2};

  typedef struct {
    logic              op;
    logic [IdW-1:0]    id;
    logic signed [2:0] nice;
    logic [15:0]       elapsed;
  } sched_word_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     id;
    logic [VrW-1:0]     vr;
    logic [CountW-1:0]  count;
  } head_result_t;

  typedef bit [WeightW-1:0] weight_set_t[NumWeights];

  class head_task_predictor;
    bit [IdW-1:0]     task_ids[MaxTasks];
    int               nice_idx[MaxTasks];
    bit [VrW-1:0]     vruntimes[MaxTasks];
    int               held;
    bit [WeightW-1:0] weights[NumWeights];
    head_result_t     expected_heads[$];
    int               errors;

    function new();
      held = 0;
      errors = 0;
      foreach (weights[i]) weights[i] = WeightReset;
    endfunction

    function void set_weight(logic [CfgIdxW-1:0] idx, bit [WeightW-1:0] value);
      weights[idx] = value;
    endfunction

    function void swap_entries(int a, int b);
      bit [IdW-1:0] t_id;
      int           t_nice;
      bit [VrW-1:0] t_vr;
      t_id = task_ids[a];
      t_nice = nice_idx[a];
      t_vr = vruntimes[a];
      task_ids[a] = task_ids[b];
      nice_idx[a] = nice_idx[b];
      vruntimes[a] = vruntimes[b];
      task_ids[b] = t_id;
      nice_idx[b] = t_nice;
      vruntimes[b] = t_vr;
    endfunction

    // Works out the head after one accepted word and queues it.
    function void note_word(sched_word_t w);
      head_result_t r;
      int           lvl;
      bit [31:0]    charge;
      bit [VrW:0]   sum;
      r.status = StatusOk;
      if (w.op == OpAdd) begin
        if (held >= MaxTasks) begin
          r.status = StatusFull;
        end else begin
          lvl = int'(w.nice);
          if (lvl < -2) lvl = -2;
          if (lvl > 2) lvl = 2;
          task_ids[held] = w.id;
          nice_idx[held] = lvl + 2;
          vruntimes[held] = '0;
          held++;
        end
      end else begin
        if (held == 0) begin
          r.status = StatusEmpty;
        end else begin
          charge = 32'(w.elapsed) * 32'(weights[nice_idx[0]]);
          sum = {1'b0, vruntimes[0]} + (VrW + 1)'(charge);
          vruntimes[0] = sum[VrW] ? {VrW{1'b1}} : sum[VrW-1:0];
          for (int i = 0; i < held; i++) begin
            for (int j = 0; j + 1 + i < held; j++) begin
              if (vruntimes[j] > vruntimes[j+1]) swap_entries(j, j + 1);
            end
          end
        end
      end
      r.id = (held > 0) ? task_ids[0] : '0;
      r.vr = (held > 0) ? vruntimes[0] : '0;
      r.count = CountW'(held);
      expected_heads.push_back(r);
    endfunction

    function void check_result(head_result_t got);
      head_result_t exp_r;
      if (expected_heads.size() == 0) begin
        $display("%0t: result word with none expected, status %0d id %h", $time,
                 got.status, got.id);
        errors++;
        return;
      end
      exp_r = expected_heads.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                 exp_r.status, got.status);
        errors++;
      end
      if (got.id !== exp_r.id) begin
        $display("%0t: next_task_id mismatch, expected %h, actual %h", $time,
                 exp_r.id, got.id);
        errors++;
      end
      if (got.vr !== exp_r.vr) begin
        $display("%0t: next_vruntime mismatch, expected %h, actual %h", $time,
                 exp_r.vr, got.vr);
        errors++;
      end
      if (got.count !== exp_r.count) begin
        $display("%0t: task_count mismatch, expected %0d, actual %0d", $time,
                 exp_r.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [WeightW-1:0]  cfg_data_i;

  mvts_in_if in_ch ();
  mvts_out_if #(.CountW(CountW)) out_ch ();

  min_vruntime_task_scheduler_unit #(
    .MaxTasks(MaxTasks)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  head_task_predictor heads = new();

  bit sender_idling;
  bit receiver_idling;
  bit hold_request;
  int hold_left;
  int stall_left;
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    head_result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.id = out_ch.next_task_id;
      got.vr = out_ch.next_vruntime;
      got.count = out_ch.task_count;
      heads.check_result(got);
    end
  end

  // The receiver: random stall bursts, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LongHold - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic int sender_gap();
    if (sender_idling && $urandom_range(0, 3) == 0) return $urandom_range(1, 19);
    return 0;
  endfunction

  function automatic sched_word_t add_word(logic [IdW-1:0] id, logic [2:0] nice);
    sched_word_t w;
    w.op = OpAdd;
    w.id = id;
    w.nice = nice;
    w.elapsed = 16'($urandom);
    return w;
  endfunction

  function automatic sched_word_t tick_word(logic [15:0] elapsed);
    sched_word_t w;
    w.op = OpTick;
    w.id = 16'($urandom);
    w.nice = 3'($urandom);
    w.elapsed = elapsed;
    return w;
  endfunction

  function automatic sched_word_t random_word();
    logic [15:0] elapsed;
    case ($urandom_range(0, 4))
      0: elapsed = '0;
      1: elapsed = '1;
      2: elapsed = 16'($urandom_range(1, 15));
      default: elapsed = 16'($urandom);
    endcase
    if ($urandom_range(0, 9) < 7) return tick_word(elapsed);
    return add_word(16'($urandom), 3'($urandom_range(0, 7)));
  endfunction

  task automatic send_word(sched_word_t w);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.operation <= w.op;
    in_ch.task_id <= w.id;
    in_ch.nice_level <= w.nice;
    in_ch.elapsed_time <= w.elapsed;
    do @(posedge clk_i); while (!in_ch.ready);
    heads.note_word(w);
  endtask

  task automatic send_random(int n);
    repeat (n) send_word(random_word());
  endtask

  // Lets the block drain completely before the weights are touched.
  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (heads.expected_heads.size() != 0) @(posedge clk_i);
    repeat (MaxTasks + 6) @(posedge clk_i);
  endtask

  task automatic write_weights(weight_set_t ws);
    for (int i = 0; i < NumWeights; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= WeightRegs[i];
      cfg_data_i <= ws[i];
      heads.set_weight(WeightRegs[i], ws[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    weight_set_t ws;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OpAdd;
    in_ch.task_id = '0;
    in_ch.nice_level = '0;
    in_ch.elapsed_time = '0;
    out_ch.ready = 1'b0;
    sender_idling = 1'b1;
    receiver_idling = 1'b1;
    hold_request = 1'b0;
    hold_left = 0;
    stall_left = 0;
    cycle_count = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: empty table, a lone task, nice clamping, duplicates
    // and a full table, all under the reset weights.
    send_word(tick_word(16'h1234));
    send_word(add_word(16'h0000, 3'b110));
    send_word(tick_word(16'hffff));
    send_word(tick_word(16'h0000));
    send_word(add_word(16'hffff, 3'b010));
    send_word(add_word(16'h0000, 3'b011));
    send_word(add_word(16'h1234, 3'b101));
    send_word(add_word(16'h5555, 3'b100));
    send_word(add_word(16'haaaa, 3'b111));
    send_word(add_word(16'h00ff, 3'b000));
    send_word(add_word(16'hff00, 3'b001));
    send_word(tick_word(16'h0001));
    send_word(tick_word(16'hffff));
    send_word(tick_word(16'h0000));
    send_word(tick_word(16'h0003));
    repeat (8) send_word(add_word(16'($urandom), 3'($urandom_range(0, 7))));
    send_word(add_word(16'hbeef, 3'b000));
    send_word(tick_word(16'h8000));
    send_random(250);
    wait_idle();

    // Largest weights, with one long hold-off on the result side.
    foreach (ws[i]) ws[i] = '1;
    write_weights(ws);
    hold_request = 1'b1;
    send_random(250);
    wait_idle();

    // Zero weights: every tick leaves the order to the ties.
    foreach (ws[i]) ws[i] = '0;
    write_weights(ws);
    send_random(250);
    wait_idle();

    ws = '{16'h0001, 16'hffff, 16'h0000, 16'h8000, 16'h7fff};
    write_weights(ws);
    send_random(250);
    wait_idle();

    foreach (ws[i]) ws[i] = 16'($urandom);
    write_weights(ws);
    send_random(200);
    wait_idle();

    // Closing stretch at full rate on both sides.
    foreach (ws[i]) ws[i] = WeightReset;
    write_weights(ws);
    sender_idling = 1'b0;
    receiver_idling = 1'b0;
    send_random(150);
    wait_idle();

    if (heads.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mvts_pkg.sv
rtl/mvts_if.sv
rtl/mvts_cell.sv
rtl/min_vruntime_task_scheduler_unit.sv
dv/testbench.sv
